// ===== sv/gbnsl_pkg.sv =====
// Shared types and constants for the go-back-N segmenting link.
`timescale 1ns / 1ps
package gbnsl_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = SLOT_W + 1;
  localparam int LEN_W       = 12;

  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_RECV = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] CFG_SESSION = 2'd0;
  localparam logic [1:0] CFG_WINDOW  = 2'd1;
  localparam logic [1:0] CFG_PAYLOAD = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  localparam logic [2:0] EV_SEND    = 3'd0;
  localparam logic [2:0] EV_ACK     = 3'd1;
  localparam logic [2:0] EV_DELIVER = 3'd2;
  localparam logic [2:0] EV_DONE    = 3'd3;
  localparam logic [2:0] EV_REJECT  = 3'd4;

  typedef enum logic [1:0] {OP_ENQ, OP_ACK, OP_DATA, OP_TICK} op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EXEC, S_DLV, S_RDF, S_SEND, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       header;
    logic [LEN_W-1:0] length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       event_res;
    logic [7:0]       frame_header;
    logic [2:0]       slot;
    logic [LEN_W-1:0] offset;
    logic [7:0]       payload_length;
    logic             last;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       header;
    logic [LEN_W-1:0] length;
  } req_t;

  typedef struct packed {
    logic [3:0]  session_id;
    logic [3:0]  window_frames;
    logic [7:0]  payload_per_frame;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

// ===== sv/gbnsl_front.sv =====
// Front end: classifies incoming requests and queues them for the back end.
`timescale 1ns / 1ps
module gbnsl_front import gbnsl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  input  cfg_t     cfg,
  output logic     req_valid,
  output req_t     req,
  input  logic     req_pop
);

  req_t       fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       keep;
  req_t       cls;

  // Foreign-session, empty and unknown requests produce nothing and are dropped here.
  always_comb begin
    cls.header = in_item.header;
    cls.length = in_item.length;
    cls.op     = OP_TICK;
    keep       = 1'b0;
    case (in_item.kind)
      KIND_ENQ: begin
        cls.op = OP_ENQ;
        keep   = 1'b1;
      end
      KIND_RECV: begin
        cls.op = (in_item.length == LEN_W'(1)) ? OP_ACK : OP_DATA;
        keep   = (in_item.header[7:4] == cfg.session_id) && (in_item.length != '0);
      end
      KIND_TICK: begin
        cls.op = OP_TICK;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign busy      = (count_r == 2'd2);
  assign req_valid = (count_r != 2'd0);
  assign req       = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (start && !busy && keep) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (start && !busy && keep) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (req_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(start && !busy && keep) - 2'(req_pop);
    end
  end

endmodule

// ===== sv/gbnsl_back.sv =====
// Back end: message store, sender window, receiver and watchdog sequencer.
`timescale 1ns / 1ps
module gbnsl_back import gbnsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      req_valid,
  input  req_t      req,
  output logic      req_pop,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic [LEN_W-1:0] mem [QUEUE_DEPTH];
  logic [LEN_W-1:0] rd_head_r, rd_send_r;

  state_t state_r, state_nxt;
  req_t   item_r, item_nxt;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt, sidx_r, sidx_nxt;
  logic [LEN_W-1:0]   soff_r, soff_nxt, aoff_r, aoff_nxt;
  logic [3:0]  sseq_r, sseq_nxt, aseq_r, aseq_nxt, rseq_r, rseq_nxt, infl_r, infl_nxt;
  logic        wd_r, wd_nxt, fill_r, fill_nxt;
  logic [15:0] idle_r, idle_nxt, idle_inc;
  out_item_t   pend_r, gen;
  logic        pend_v_r, gen_v, mem_we;
  logic [SLOT_W-1:0] wr_slot, send_slot;
  logic [7:0]  chunk;
  logic [LEN_W:0] ack_sum, send_end, send_min;
  logic [LEN_W-1:0] dlv_len;

  assign wr_slot   = head_r + count_r[SLOT_W-1:0];
  assign send_slot = head_r + sidx_r[SLOT_W-1:0];
  assign chunk     = (cfg.payload_per_frame == 8'd0) ? 8'd1 : cfg.payload_per_frame;
  assign ack_sum   = {1'b0, aoff_r} + (LEN_W+1)'(chunk);
  assign send_end  = {1'b0, soff_r} + (LEN_W+1)'(chunk);
  assign send_min  = (send_end < {1'b0, rd_send_r}) ? send_end : {1'b0, rd_send_r};
  assign idle_inc  = (idle_r == 16'hffff) ? idle_r : idle_r + 16'd1;
  assign dlv_len   = item_r.length - LEN_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_slot] <= item_r.length;
    end
    rd_head_r <= mem[head_r];
    rd_send_r <= mem[send_slot];
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    sidx_nxt  = sidx_r;
    soff_nxt  = soff_r;
    aoff_nxt  = aoff_r;
    sseq_nxt  = sseq_r;
    aseq_nxt  = aseq_r;
    rseq_nxt  = rseq_r;
    infl_nxt  = infl_r;
    wd_nxt    = wd_r;
    fill_nxt  = fill_r;
    idle_nxt  = idle_r;
    req_pop   = 1'b0;
    mem_we    = 1'b0;
    gen_v     = 1'b0;
    gen       = '0;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_pop   = 1'b1;
          item_nxt  = req;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_DONE;
        case (item_r.op)
          OP_ENQ: begin
            if (count_r >= COUNT_W'(QUEUE_DEPTH)) begin
              gen_v         = 1'b1;
              gen.event_res = EV_REJECT;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + COUNT_W'(1);
              if (!wd_r) begin
                wd_nxt   = 1'b1;
                idle_nxt = 16'd0;
              end
              fill_nxt  = 1'b1;
              state_nxt = S_RDF;
            end
          end
          OP_ACK: begin
            if (count_r != '0 && item_r.header[3:0] == aseq_r) begin
              aseq_nxt = aseq_r + 4'd1;
              idle_nxt = 16'd0;
              if ({1'b0, rd_head_r} <= ack_sum) begin
                gen_v            = 1'b1;
                gen.event_res    = EV_DONE;
                gen.frame_header = item_r.header;
                gen.slot         = 3'(head_r);
                head_nxt         = head_r + SLOT_W'(1);
                count_nxt        = count_r - COUNT_W'(1);
                if (sidx_r != '0) begin
                  sidx_nxt = sidx_r - COUNT_W'(1);
                end else begin
                  soff_nxt = '0;
                end
                aoff_nxt = '0;
              end else begin
                aoff_nxt = ack_sum[LEN_W-1:0];
              end
              fill_nxt  = 1'b0;
              state_nxt = S_RDF;
            end
          end
          OP_DATA: begin
            gen_v            = 1'b1;
            gen.event_res    = EV_ACK;
            gen.frame_header = item_r.header;
            if (item_r.header[3:0] == rseq_r) begin
              state_nxt = S_DLV;
            end
          end
          default: begin
            if (wd_r) begin
              idle_nxt = idle_inc;
              if (idle_inc >= cfg.timeout_ticks) begin
                idle_nxt = 16'd0;
                if (count_r != '0) begin
                  infl_nxt  = 4'd0;
                  sidx_nxt  = '0;
                  soff_nxt  = aoff_r;
                  sseq_nxt  = aseq_r;
                  fill_nxt  = 1'b1;
                  state_nxt = S_RDF;
                end else begin
                  wd_nxt = 1'b0;
                end
              end
            end
          end
        endcase
      end
      S_DLV: begin
        gen_v              = 1'b1;
        gen.event_res      = EV_DELIVER;
        gen.frame_header   = item_r.header;
        gen.payload_length = (dlv_len > LEN_W'(255)) ? 8'd255 : dlv_len[7:0];
        rseq_nxt           = rseq_r + 4'd1;
        state_nxt          = S_DONE;
      end
      S_RDF: state_nxt = S_SEND;
      S_SEND: begin
        state_nxt = S_DONE;
        if ((sidx_r < count_r) && (!fill_r || infl_r < cfg.window_frames)) begin
          gen_v            = 1'b1;
          gen.event_res    = EV_SEND;
          gen.frame_header = {cfg.session_id, sseq_r};
          gen.slot         = 3'(send_slot);
          gen.offset       = soff_r;
          gen.payload_length = (soff_r >= rd_send_r) ? 8'd0 :
                               8'(send_min - {1'b0, soff_r});
          sseq_nxt = sseq_r + 4'd1;
          if ({1'b0, rd_send_r} <= send_end) begin
            sidx_nxt = sidx_r + COUNT_W'(1);
            soff_nxt = '0;
          end else begin
            soff_nxt = send_end[LEN_W-1:0];
          end
          if (fill_r) begin
            infl_nxt  = infl_r + 4'd1;
            state_nxt = S_RDF;
          end
        end else if (!fill_r && infl_r != 4'd0) begin
          infl_nxt = infl_r - 4'd1;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // A result is held until the next one or S_DONE, so the last is marked.
  assign out_strobe = pend_v_r && (gen_v || state_r == S_DONE);
  always_comb begin
    out_item      = pend_r;
    out_item.last = (state_r == S_DONE);
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    if (gen_v) begin
      pend_r <= gen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      sidx_r   <= '0;
      soff_r   <= '0;
      aoff_r   <= '0;
      sseq_r   <= '0;
      aseq_r   <= '0;
      rseq_r   <= '0;
      infl_r   <= '0;
      wd_r     <= 1'b0;
      fill_r   <= 1'b0;
      idle_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      sidx_r  <= sidx_nxt;
      soff_r  <= soff_nxt;
      aoff_r  <= aoff_nxt;
      sseq_r  <= sseq_nxt;
      aseq_r  <= aseq_nxt;
      rseq_r  <= rseq_nxt;
      infl_r  <= infl_nxt;
      wd_r    <= wd_nxt;
      fill_r  <= fill_nxt;
      idle_r  <= idle_nxt;
      if (gen_v) begin
        pend_v_r <= 1'b1;
      end else if (state_r == S_DONE) begin
        pend_v_r <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/go_back_n_segmenting_link.sv =====
// Top level of the go-back-N segmenting link controller.
`timescale 1ns / 1ps
// Usage:
// A request is taken on in_item at a rising edge where start is high and busy
// is low. Requests are enqueue message, frame received and one-millisecond tick.
// The front end classifies each request and drops those that cause nothing
// (frames of another session, empty frames, unknown kinds); the rest wait in a
// two-entry queue, and busy is high while that queue is full.
// The back end handles one request at a time. Each result appears on out_item
// for one cycle with out_strobe high; out_item.last marks the final result of
// the request. The receiver cannot stall, so results are never held.
// Sequence: a request waits in the queue, then passes through a store read and a
// decode state; results follow, except that each sent frame first re-reads the
// message store, and a closing state ends the request. A window fill also ends
// with a final window check that sends nothing. Configuration is written through
// cfg_we, cfg_index and cfg_data while idle; the user must keep to this, as the
// block itself does not enforce it.
// Synchronous reset clears the queues, sequence numbers, window and watchdog
// and restores the register defaults; store contents are undefined until written.
module go_back_n_segmenting_link import gbnsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic      out_strobe,
  output out_item_t out_item
);

  cfg_t cfg_r;
  logic req_valid, req_pop;
  req_t req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.session_id        <= 4'd0;
      cfg_r.window_frames     <= 4'd4;
      cfg_r.payload_per_frame <= 8'd49;
      cfg_r.timeout_ticks     <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SESSION: cfg_r.session_id        <= cfg_data[3:0];
        CFG_WINDOW:  cfg_r.window_frames     <= cfg_data[3:0];
        CFG_PAYLOAD: cfg_r.payload_per_frame <= cfg_data[7:0];
        CFG_TIMEOUT: cfg_r.timeout_ticks     <= cfg_data;
        default:     cfg_r.timeout_ticks     <= cfg_r.timeout_ticks;
      endcase
    end
  end

  // The front end accepts and classifies requests.
  gbnsl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  // The back end runs the sender window, receiver and watchdog.
  gbnsl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .req_valid  (req_valid),
    .req        (req),
    .req_pop    (req_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
